FILE: hw/rtl/fldf_pkg.sv
// Shared types and constants for the fixed-length frame deframer.
// No dependencies; the chain, the deframer and the testbench refer here by scoped name.
`timescale 1ns / 1ps

package fldf_pkg;

    // result kinds
    localparam logic [1:0] EV_FRAME_BYTE = 2'd0;
    localparam logic [1:0] EV_RESYNC     = 2'd1;
    localparam logic [1:0] EV_INVALID    = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_START_BYTE = 2'd0;
    localparam logic [1:0] CFG_END_BYTE   = 2'd1;
    localparam logic [1:0] CFG_SKIP_LB    = 2'd2;

    localparam logic [7:0] START_RESET = 8'h53;
    localparam logic [7:0] END_RESET   = 8'h45;
    localparam logic [7:0] BYTE_CR     = 8'h0D;
    localparam logic [7:0] BYTE_LF     = 8'h0A;

    // control of the byte chain: shift everything one cell toward the head
    typedef struct packed {
        logic       shift;
        logic [7:0] din;
    } chain_ctrl_t;

endpackage

FILE: hw/rtl/fldf_if.sv
// Valid/ready channel interfaces for received bytes and result words.
// Depends on nothing.
`timescale 1ns / 1ps

interface fldf_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fldf_ev_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    logic [7:0] frame_byte;
    logic       last_of_run;

    modport source (output valid, output event_kind, output frame_byte,
                    output last_of_run, input ready);
    modport sink   (input valid, input event_kind, input frame_byte,
                    input last_of_run, output ready);
endinterface

FILE: hw/rtl/fldf_cell.sv
// One byte cell of the frame chain.
// Depends on nothing; the chain hands it the shared shift enable.
`timescale 1ns / 1ps

module fldf_cell (
    input  logic                      clk,
    input  logic                      shift,
    input  logic [7:0]                neighbor,
    output logic [7:0]                q
);

    logic [7:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= neighbor;
        end
    end

    assign q = data_reg;

endmodule

FILE: hw/rtl/fldf_chain.sv
// Row of byte cells holding one frame; new bytes enter at the tail,
// the oldest byte sits at the head. Depends on fldf_pkg and fldf_cell.
`timescale 1ns / 1ps

module fldf_chain #(
    parameter int FRAME_LEN = 14
) (
    input  logic                  clk,
    input  fldf_pkg::chain_ctrl_t ctrl,
    output logic [7:0]            head
);

    logic [7:0] cell_q [FRAME_LEN];

    for (genvar i = 0; i < FRAME_LEN; i++)
    begin : g_cell
        logic [7:0] nb;
        if (i == FRAME_LEN - 1)
        begin : g_tail
            assign nb = ctrl.din;
        end
        else
        begin : g_mid
            assign nb = cell_q[i + 1];
        end

        fldf_cell u_cell (
            .clk      (clk),
            .shift    (ctrl.shift),
            .neighbor (nb),
            .q        (cell_q[i])
        );
    end

    assign head = cell_q[0];

endmodule

FILE: hw/rtl/fixed_length_frame_deframer_unit.sv
// Fixed-length frame deframer: start byte, DATA_LENGTH bytes, end byte.
// Output: resync / invalid word in the cycle after its byte; a good frame's
//   words come one per cycle from the chain head once drain is set, unless stalled.
// Throughput: 1 byte per cycle; input held off while a good frame drains
//   (chain shift is the only path to the output) and under output stalls.
// Reset: rst_n async, idle waiting for start, registers to 'S', 'E', skip on.
`timescale 1ns / 1ps

module fixed_length_frame_deframer_unit #(
    parameter int DATA_LENGTH = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    fldf_rx_if.sink     rx,
    fldf_ev_if.source   ev
);

    localparam int FRAME_LEN = DATA_LENGTH + 2;
    localparam int POS_W     = $clog2(FRAME_LEN);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_LEN - 1);

    // configuration
    logic [7:0] start_byte_reg;
    logic [7:0] end_byte_reg;
    logic       skip_lb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= fldf_pkg::START_RESET;
            end_byte_reg   <= fldf_pkg::END_RESET;
            skip_lb_reg    <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fldf_pkg::CFG_START_BYTE: start_byte_reg <= cfg_data;
                fldf_pkg::CFG_END_BYTE:   end_byte_reg   <= cfg_data;
                fldf_pkg::CFG_SKIP_LB:    skip_lb_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // control state
    logic             in_frame_reg,  in_frame_next;
    logic [POS_W-1:0] fill_reg,      fill_next;
    logic             drain_reg,     drain_next;   // replaying a good frame
    logic [POS_W-1:0] drain_cnt_reg, drain_cnt_next;

    // output word register
    logic       ev_valid_reg, ev_valid_next;
    logic [1:0] ev_kind_reg,  ev_kind_next;
    logic [7:0] ev_byte_reg,  ev_byte_next;
    logic       ev_last_reg,  ev_last_next;

    fldf_pkg::chain_ctrl_t chain_ctrl;
    logic [7:0]            chain_head;

    logic       slot_free;
    logic       accept;
    logic [7:0] b;
    logic       skip;

    // a byte is taken only when the output slot can hold whatever it causes
    assign slot_free = !ev_valid_reg || ev.ready;
    assign rx.ready  = !drain_reg && slot_free;
    assign accept    = rx.valid && rx.ready;
    assign b         = rx.rx_byte;
    assign skip      = skip_lb_reg && (b == fldf_pkg::BYTE_CR || b == fldf_pkg::BYTE_LF);

    always_comb
    begin
        in_frame_next    = in_frame_reg;
        fill_next        = fill_reg;
        drain_next       = drain_reg;
        drain_cnt_next   = drain_cnt_reg;
        ev_valid_next    = ev_valid_reg && !ev.ready;
        ev_kind_next     = ev_kind_reg;
        ev_byte_next     = ev_byte_reg;
        ev_last_next     = ev_last_reg;
        chain_ctrl.shift = 1'b0;
        chain_ctrl.din   = b;

        if (accept && !skip)
        begin
            if (b == start_byte_reg)
            begin
                // opens a frame, or restarts one already running
                chain_ctrl.shift = 1'b1;
                fill_next        = POS_W'(1);
                in_frame_next    = 1'b1;
                if (in_frame_reg)
                begin
                    ev_valid_next = 1'b1;
                    ev_kind_next  = fldf_pkg::EV_RESYNC;
                    ev_byte_next  = 8'h00;
                    ev_last_next  = 1'b1;
                end
            end
            else if (in_frame_reg)
            begin
                chain_ctrl.shift = 1'b1;
                if (fill_reg == POS_LAST)
                begin
                    in_frame_next = 1'b0;
                    fill_next     = '0;
                    if (b == end_byte_reg)
                    begin
                        drain_next     = 1'b1;
                        drain_cnt_next = '0;
                    end
                    else
                    begin
                        ev_valid_next = 1'b1;
                        ev_kind_next  = fldf_pkg::EV_INVALID;
                        ev_byte_next  = 8'h00;
                        ev_last_next  = 1'b1;
                    end
                end
                else
                begin
                    fill_next = fill_reg + POS_W'(1);
                end
            end
        end
        else if (drain_reg && slot_free)
        begin
            // pop the head of the chain into the output slot
            chain_ctrl.shift = 1'b1;
            chain_ctrl.din   = 8'h00;
            ev_valid_next    = 1'b1;
            ev_kind_next     = fldf_pkg::EV_FRAME_BYTE;
            ev_byte_next     = chain_head;
            ev_last_next     = (drain_cnt_reg == POS_LAST);
            drain_cnt_next   = drain_cnt_reg + POS_W'(1);
            if (drain_cnt_reg == POS_LAST)
            begin
                drain_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg  <= 1'b0;
            fill_reg      <= '0;
            drain_reg     <= 1'b0;
            drain_cnt_reg <= '0;
            ev_valid_reg  <= 1'b0;
        end
        else
        begin
            in_frame_reg  <= in_frame_next;
            fill_reg      <= fill_next;
            drain_reg     <= drain_next;
            drain_cnt_reg <= drain_cnt_next;
            ev_valid_reg  <= ev_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        ev_kind_reg <= ev_kind_next;
        ev_byte_reg <= ev_byte_next;
        ev_last_reg <= ev_last_next;
    end

    fldf_chain #(
        .FRAME_LEN (FRAME_LEN)
    ) u_chain (
        .clk  (clk),
        .ctrl (chain_ctrl),
        .head (chain_head)
    );

    assign ev.valid       = ev_valid_reg;
    assign ev.event_kind  = ev_kind_reg;
    assign ev.frame_byte  = ev_byte_reg;
    assign ev.last_of_run = ev_last_reg;

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for fixed_length_frame_deframer_unit: a directed byte table,
// then phases of random frame traffic under several register settings and idle patterns.
// Depends on fldf_pkg, the channel interfaces in fldf_if.sv and the deframer RTL.

module testbench;

    localparam int DATA_LENGTH  = 12;
    localparam int FRAME_WORDS  = DATA_LENGTH + 2;
    // a good frame drains 14 words after its last byte is taken
    localparam int DRAIN_CYCLES = FRAME_WORDS + 6;
    localparam int LONG_HOLD    = 300;
    // no register lives at this index; writes to it must be ignored
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    // how the expectation for a table row is formed
    typedef enum int {ROW_MODEL, ROW_QUIET, ROW_RESYNC, ROW_INVALID} row_kind_e;
    typedef enum int {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_e;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] fbyte;
        logic       last;
    } ev_word_t;

    typedef struct {
        logic [7:0] b;
        row_kind_e  kind;
    } rx_item_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    fldf_rx_if rx_ch();
    fldf_ev_if ev_ch();

    fixed_length_frame_deframer_unit #(
        .DATA_LENGTH(DATA_LENGTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .rx(rx_ch.sink),
        .ev(ev_ch.source)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Directed table. Reset settings: start 'S', end 'E', line breaks skipped.
    // First frame: idle drops, a skipped CR while idle, a resync on a second
    // start byte, a skipped LF inside the frame, then a wrong final byte.
    // Second frame: byte extremes as data, closed by the end byte.
    // ------------------------------------------------------------------
    rx_item_t directed_rows [32] = '{
        '{8'hFF, ROW_QUIET},                 // idle, not start: dropped
        '{fldf_pkg::BYTE_CR, ROW_QUIET},     // skipped before parsing
        '{fldf_pkg::START_RESET, ROW_QUIET}, // opens frame
        '{fldf_pkg::START_RESET, ROW_RESYNC},
        '{fldf_pkg::BYTE_LF, ROW_QUIET},     // skipped, does not advance the fill
        '{8'h00, ROW_QUIET},
        '{8'hFF, ROW_QUIET},
        '{fldf_pkg::END_RESET, ROW_QUIET},   // end byte in a data slot is plain data
        '{8'h01, ROW_QUIET},
        '{8'h80, ROW_QUIET},
        '{8'h7F, ROW_QUIET},
        '{8'h55, ROW_QUIET},
        '{8'hAA, ROW_QUIET},
        '{8'h0F, ROW_QUIET},
        '{8'hF0, ROW_QUIET},
        '{8'h02, ROW_QUIET},
        '{8'hFE, ROW_QUIET},
        '{8'h44, ROW_INVALID},               // final slot is not the end byte
        '{fldf_pkg::START_RESET, ROW_QUIET},
        '{8'hFF, ROW_QUIET},
        '{8'h00, ROW_QUIET},
        '{fldf_pkg::END_RESET, ROW_QUIET},
        '{8'h10, ROW_QUIET},
        '{8'hAA, ROW_QUIET},
        '{8'h55, ROW_QUIET},
        '{8'h01, ROW_QUIET},
        '{8'hFE, ROW_QUIET},
        '{8'h7F, ROW_QUIET},
        '{8'h80, ROW_QUIET},
        '{8'h0C, ROW_QUIET},
        '{8'h0B, ROW_QUIET},
        '{fldf_pkg::END_RESET, ROW_MODEL}    // whole frame replayed, 14 words
    };

    // bytes waiting to be offered, and words the block still owes us
    rx_item_t rx_queue [$];
    ev_word_t pending_words [$];
    ev_word_t model_out [$];

    rx_item_t tx_cur;
    ev_word_t got_word;
    ev_word_t want_word;

    int   err_count;
    int   tx_idle_pct;
    int   rx_stall_pct;
    int   hold_count;
    logic hold_request;
    logic long_hold;

    // predictor copy of registers and parser state
    logic [7:0] m_start;
    logic [7:0] m_end;
    logic       m_skip;
    logic       m_in_frame;
    int         m_fill;
    logic [7:0] m_store [FRAME_WORDS];

    function automatic void flag_error(input string msg);
        err_count++;
        if (err_count <= 10)
        begin
            $display("[%0t] %s", $time, msg);
        end
    endfunction

    // Parse one received byte; words it causes land in model_out.
    function automatic void deframe_byte(input logic [7:0] b);
        int k;
        model_out.delete();
        if (m_skip && (b == fldf_pkg::BYTE_CR || b == fldf_pkg::BYTE_LF))
        begin
            return;
        end
        if (!m_in_frame)
        begin
            if (b == m_start)
            begin
                m_in_frame = 1'b1;
                m_store[0] = b;
                m_fill     = 1;
            end
            return;
        end
        // start byte always wins, even when it equals the end byte
        if (b == m_start)
        begin
            m_store[0] = b;
            m_fill     = 1;
            model_out.push_back('{fldf_pkg::EV_RESYNC, 8'h00, 1'b1});
            return;
        end
        m_store[m_fill] = b;
        m_fill++;
        if (m_fill < FRAME_WORDS)
        begin
            return;
        end
        m_in_frame = 1'b0;
        m_fill     = 0;
        if (m_store[FRAME_WORDS-1] == m_end)
        begin
            for (k = 0; k < FRAME_WORDS; k++)
            begin
                model_out.push_back('{fldf_pkg::EV_FRAME_BYTE, m_store[k],
                                      k == FRAME_WORDS - 1});
            end
        end
        else
        begin
            model_out.push_back('{fldf_pkg::EV_INVALID, 8'h00, 1'b1});
        end
    endfunction

    function automatic void offer(input logic [7:0] b);
        rx_queue.push_back('{b, ROW_MODEL});
    endfunction

    // data slot content, biased toward the bytes the parser treats specially
    function automatic logic [7:0] frame_data();
        int r;
        r = $urandom_range(99);
        if (r < 3)
        begin
            return m_start;
        end
        if (r < 8)
        begin
            return m_end;
        end
        if (r < 12)
        begin
            return $urandom_range(1) ? fldf_pkg::BYTE_CR : fldf_pkg::BYTE_LF;
        end
        return 8'($urandom_range(255));
    endfunction

    // Mostly well-formed frames with random content; the rest is truncated
    // frames (resynced by the next start) and loose noise.
    task automatic queue_traffic(input int n);
        int count;
        int pick;
        int len;
        int i;
        count = 0;
        while (count < n)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
            begin
                offer(m_start);
                for (i = 0; i < DATA_LENGTH; i++)
                begin
                    if ($urandom_range(11) == 0)
                    begin
                        offer($urandom_range(1) ? fldf_pkg::BYTE_CR : fldf_pkg::BYTE_LF);
                    end
                    offer(frame_data());
                end
                offer(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : m_end);
                count += FRAME_WORDS;
            end
            else if (pick < 87)
            begin
                len = $urandom_range(1, DATA_LENGTH - 1);
                offer(m_start);
                for (i = 0; i < len; i++)
                begin
                    offer(frame_data());
                end
                count += len + 1;
            end
            else
            begin
                len = $urandom_range(1, 4);
                for (i = 0; i < len; i++)
                begin
                    offer(8'($urandom_range(255)));
                end
                count += len;
            end
        end
    endtask

    task automatic set_idle(input idle_mode_e mode);
        case (mode)
            IDLE_TX:
            begin
                tx_idle_pct  = 63;
                rx_stall_pct = 0;
            end
            IDLE_RX:
            begin
                tx_idle_pct  = 0;
                rx_stall_pct = 63;
            end
            IDLE_BOTH:
            begin
                tx_idle_pct  = 12;
                rx_stall_pct = 12;
            end
            default:
            begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end
        endcase
    endtask

    // Back-to-back register writes; write enable stays high across them.
    // Only called while idle, so the predictor copy can change at once.
    task automatic load_settings(input logic [7:0] sb, input logic [7:0] eb,
                                 input logic skip);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= fldf_pkg::CFG_START_BYTE;
        cfg_data  <= sb;
        m_start    = sb;
        @(posedge clk);
        cfg_index <= fldf_pkg::CFG_END_BYTE;
        cfg_data  <= eb;
        m_end      = eb;
        @(posedge clk);
        cfg_index <= fldf_pkg::CFG_SKIP_LB;
        cfg_data  <= {7'($urandom_range(127)), skip};   // only bit 0 counts
        m_skip     = skip;
        @(posedge clk);
        cfg_index <= CFG_UNUSED;
        cfg_data  <= 8'($urandom_range(255));
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // all bytes taken, all words back, then the drain window
    task automatic wait_quiet();
        while (rx_queue.size() != 0 || rx_ch.valid || pending_words.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Byte sender. On acceptance the predictor runs; table rows with a
    // typed outcome use it in place of the predicted words.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rx_ch.valid && rx_ch.ready)
            begin
                deframe_byte(tx_cur.b);
                case (tx_cur.kind)
                    ROW_MODEL:
                    begin
                        foreach (model_out[i])
                        begin
                            pending_words.push_back(model_out[i]);
                        end
                    end
                    ROW_RESYNC:
                        pending_words.push_back('{fldf_pkg::EV_RESYNC, 8'h00, 1'b1});
                    ROW_INVALID:
                        pending_words.push_back('{fldf_pkg::EV_INVALID, 8'h00, 1'b1});
                    default:     ;
                endcase
            end
            if (!rx_ch.valid || rx_ch.ready)
            begin
                if (rx_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    tx_cur = rx_queue.pop_front();
                    rx_ch.valid   <= 1'b1;
                    rx_ch.rx_byte <= tx_cur.b;
                end
                else
                begin
                    rx_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Word receiver: every accepted word is checked against the oldest
    // expectation; ready drops at random or during the long hold.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (ev_ch.valid && ev_ch.ready)
            begin
                got_word = '{ev_ch.event_kind, ev_ch.frame_byte, ev_ch.last_of_run};
                if (pending_words.size() == 0)
                begin
                    flag_error($sformatf("unexpected word: kind %0d byte %02h last %0d",
                                         got_word.kind, got_word.fbyte, got_word.last));
                end
                else
                begin
                    want_word = pending_words.pop_front();
                    if (got_word.kind !== want_word.kind || got_word.fbyte !== want_word.fbyte
                        || got_word.last !== want_word.last)
                    begin
                        flag_error($sformatf(
                            "word mismatch: kind %0d/%0d byte %02h/%02h last %0d/%0d (exp/act)",
                            want_word.kind, got_word.kind, want_word.fbyte, got_word.fbyte,
                            want_word.last, got_word.last));
                    end
                end
            end
            ev_ch.ready <= !long_hold && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Long receiver hold-off, counted here so the sender keeps pushing and
    // the block has to back up into its input.
    initial
    begin
        long_hold = 1'b0;
        wait (hold_request);
        @(posedge clk);
        long_hold <= 1'b1;
        for (hold_count = 0; hold_count < LONG_HOLD; hold_count++)
        begin
            @(posedge clk);
        end
        long_hold <= 1'b0;
    end

    // run limit, far above the slowest legal run
    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = fldf_pkg::CFG_START_BYTE;
        cfg_data      = 8'h00;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        ev_ch.ready   = 1'b0;
        hold_request  = 1'b0;
        err_count     = 0;
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        m_start       = fldf_pkg::START_RESET;
        m_end         = fldf_pkg::END_RESET;
        m_skip        = 1'b1;
        m_in_frame    = 1'b0;
        m_fill        = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table on reset settings
        set_idle(IDLE_NONE);
        foreach (directed_rows[i])
        begin
            rx_queue.push_back(directed_rows[i]);
        end
        wait_quiet();

        // reset values rewritten; the sender pauses halfway until all words are back
        load_settings(fldf_pkg::START_RESET, fldf_pkg::END_RESET, 1'b1);
        queue_traffic(20);
        wait_quiet();
        queue_traffic(20);
        wait_quiet();

        // low/high extremes, line breaks parsed as data; leave a frame open
        set_idle(IDLE_TX);
        load_settings(8'h00, 8'hFF, 1'b0);
        queue_traffic(30);
        offer(m_start);
        repeat (5) offer(8'($urandom_range(255)));
        wait_quiet();

        // settings change under the open frame; long receiver hold-off
        set_idle(IDLE_RX);
        load_settings(8'hFF, 8'h00, 1'b1);
        hold_request = 1'b1;
        queue_traffic(50);
        wait_quiet();

        // end byte equal to start byte: an end byte in the final slot always resyncs
        set_idle(IDLE_BOTH);
        load_settings(fldf_pkg::BYTE_CR, fldf_pkg::BYTE_CR, 1'b0);
        queue_traffic(30);
        wait_quiet();

        set_idle(idle_mode_e'($urandom_range(3)));
        load_settings(8'($urandom_range(255)), 8'($urandom_range(255)), 1'($urandom_range(1)));
        queue_traffic(30);
        wait_quiet();

        set_idle(IDLE_BOTH);
        load_settings(fldf_pkg::START_RESET, fldf_pkg::END_RESET, 1'b1);
        queue_traffic(30);
        wait_quiet();

        if (err_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
